/* sv/hmt_pkg.sv */
// Shared types, widths and codes for the heartbeat membership table.
`default_nettype none
package hmt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Fixed result field widths
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam ptr_t SCAN_END = ptr_t'(TABLE_ENTRIES);
  localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);

  // Item kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_FAIL_TIMEOUT   = 1'b0;
  localparam logic CFG_REMOVE_TIMEOUT = 1'b1;

  localparam logic [15:0] FAIL_TIMEOUT_RST   = 16'd5;
  localparam logic [15:0] REMOVE_TIMEOUT_RST = 16'd20;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Result status codes
  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_UNCHANGED = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_TICK      = 3'd4
  } status_e;

  // Input word
  typedef struct packed {
    logic        kind;
    logic [31:0] peer_id;
    logic [15:0] peer_port;
    logic [31:0] heartbeat;
  } in_t;

  // Result word
  typedef struct packed {
    status_e                status;
    logic [OUT_IDX_W-1:0]   entry_index;
    logic [OUT_CNT_W-1:0]   failed_count;
    logic [OUT_CNT_W-1:0]   removed_count;
  } out_t;

  // One slot of the payload memory
  typedef struct packed {
    logic [31:0] peer_id;
    logic [15:0] peer_port;
    logic [31:0] heartbeat;
    logic [31:0] stamp;
  } slot_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    slot_t wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

/* sv/hmt_slot_mem.sv */
// Slot payload memory: one write port, one registered read port.
`default_nettype none
module hmt_slot_mem (
  input  wire logic              clk_i,
  input  wire hmt_pkg::mem_req_t req_i,
  output hmt_pkg::slot_t         rdata_o
);
  import hmt_pkg::*;

  slot_t mem_q [TABLE_ENTRIES];
  slot_t rdata_q;

  // Write and read one slot per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/hmt_scan.sv */
// Sequencer that walks the table one slot a cycle through a shared compare unit.
`default_nettype none
module hmt_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hmt_pkg::in_t      in_i,
  input  wire logic [15:0]       fail_timeout_i,
  input  wire logic [15:0]       remove_timeout_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output hmt_pkg::out_t          res_o,
  output hmt_pkg::mem_req_t      mem_req_o,
  input  wire hmt_pkg::slot_t    mem_rdata_i
);
  import hmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]               state_q, state_d;
  in_t                      item_q, item_d;
  logic [31:0]              time_q, time_d;
  ptr_t                     cnt_q, cnt_d;
  logic                     chk_vld_q, chk_vld_d;
  idx_t                     chk_idx_q, chk_idx_d;
  logic                     have_free_q, have_free_d;
  idx_t                     free_idx_q, free_idx_d;
  cnt_t                     nfail_q, nfail_d;
  cnt_t                     nrem_q, nrem_d;
  out_t                     res_q, res_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] failed_q, failed_d;

  logic        issue;
  logic        slot_v;
  logic        slot_f;
  logic        match;
  logic        last;
  logic [31:0] age;

  // Shared compare unit on the slot read last cycle
  assign slot_v = valid_q[chk_idx_q];
  assign slot_f = failed_q[chk_idx_q];
  assign match  = slot_v && (mem_rdata_i.peer_id == item_q.peer_id)
                  && (mem_rdata_i.peer_port == item_q.peer_port);
  assign last   = (chk_idx_q == LAST_IDX);
  assign age    = time_q - mem_rdata_i.stamp;
  assign issue  = (state_q == S_SCAN) && (cnt_q != SCAN_END);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    time_d      = time_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    nfail_d     = nfail_q;
    nrem_d      = nrem_q;
    res_d       = res_q;
    valid_d     = valid_q;
    failed_d    = failed_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    mem_req_o.rd_en             = 1'b0;
    mem_req_o.rd_addr           = cnt_q[IDX_W-1:0];
    mem_req_o.wr_en             = 1'b0;
    mem_req_o.wr_addr           = chk_idx_q;
    mem_req_o.wr_data.peer_id   = item_q.peer_id;
    mem_req_o.wr_data.peer_port = item_q.peer_port;
    mem_req_o.wr_data.heartbeat = item_q.heartbeat;
    mem_req_o.wr_data.stamp     = time_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d      = in_i;
          cnt_d       = '0;
          have_free_d = 1'b0;
          free_idx_d  = '0;
          nfail_d     = '0;
          nrem_d      = '0;
          // Advance saturating time before the sweep
          if (in_i.kind == KIND_TICK && time_q != TIME_MAX) begin
            time_d = time_q + 32'd1;
          end
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next slot read
        if (issue) begin
          mem_req_o.rd_en = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          chk_vld_d       = 1'b1;
          chk_idx_d       = cnt_q[IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (item_q.kind == KIND_TICK) begin
            // Age out live and failed slots
            if (slot_v) begin
              if (slot_f) begin
                if (age >= {16'd0, remove_timeout_i}) begin
                  valid_d[chk_idx_q]  = 1'b0;
                  failed_d[chk_idx_q] = 1'b0;
                  nrem_d              = nrem_q + 1'b1;
                end
              end else if (age >= {16'd0, fail_timeout_i}) begin
                failed_d[chk_idx_q] = 1'b1;
                nfail_d             = nfail_q + 1'b1;
              end
            end
            if (last) begin
              res_d.status        = ST_TICK;
              res_d.entry_index   = '0;
              res_d.failed_count  = OUT_CNT_W'(nfail_d);
              res_d.removed_count = OUT_CNT_W'(nrem_d);
              state_d             = S_DONE;
            end
          end else if (match) begin
            // Refresh a live, non-failed entry with a newer heartbeat; otherwise report it unchanged
            if (!slot_f && (item_q.heartbeat > mem_rdata_i.heartbeat)) begin
              mem_req_o.wr_en = 1'b1;
              res_d.status    = ST_REFRESHED;
            end else begin
              res_d.status    = ST_UNCHANGED;
            end
            res_d.entry_index   = OUT_IDX_W'(chk_idx_q);
            res_d.failed_count  = '0;
            res_d.removed_count = '0;
            chk_vld_d           = 1'b0;
            state_d             = S_DONE;
          end else begin
            // Remember the lowest free slot
            if (!slot_v && !have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = chk_idx_q;
            end
            if (last) begin
              res_d.failed_count  = '0;
              res_d.removed_count = '0;
              if (have_free_d) begin
                mem_req_o.wr_en      = 1'b1;
                mem_req_o.wr_addr    = free_idx_d;
                valid_d[free_idx_d]  = 1'b1;
                failed_d[free_idx_d] = 1'b0;
                res_d.status         = ST_INSERTED;
                res_d.entry_index    = OUT_IDX_W'(free_idx_d);
              end else begin
                res_d.status         = ST_FULL;
                res_d.entry_index    = '0;
              end
              state_d = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        // Hold the result until the output register takes it
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      time_q    <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      failed_q  <= '0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      failed_q  <= failed_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    cnt_q       <= cnt_d;
    chk_idx_q   <= chk_idx_d;
    have_free_q <= have_free_d;
    free_idx_q  <= free_idx_d;
    nfail_q     <= nfail_d;
    nrem_q      <= nrem_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

/* sv/heartbeat_membership_table.sv */
// Top level of the heartbeat membership table: config registers and output register.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i/in_ready_o  | hmt_pkg::in_t
//   out     | output    | out_valid_o/out_ready_i| hmt_pkg::out_t
//   cfg     | input     | cfg_we_i (no wait)     | cfg_index_i, cfg_wdata_i
//
// Every word, update or tick, walks the slot table one slot a cycle through
// the slot memory (one write port, one registered read port) and one compare
// unit: a tick always sweeps every slot, an update stops early on a match.
// Reset clears the valid and failed bits and the time counter at once; no clearing pass.
// A stalled output holds its word while the next input word is taken and scanned.
`default_nettype none
module heartbeat_membership_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hmt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hmt_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [15:0]   cfg_wdata_i
);
  import hmt_pkg::*;

  logic [15:0] fail_timeout_q;
  logic [15:0] remove_timeout_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_q;
  logic        res_valid;
  logic        res_ready;
  out_t        res;
  mem_req_t    mem_req;
  slot_t       mem_rdata;

  hmt_scan u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_i             (in_data_i),
    .fail_timeout_i   (fail_timeout_q),
    .remove_timeout_i (remove_timeout_q),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata)
  );

  hmt_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_timeout_q   <= FAIL_TIMEOUT_RST;
      remove_timeout_q <= REMOVE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FAIL_TIMEOUT:   fail_timeout_q   <= cfg_wdata_i;
        CFG_REMOVE_TIMEOUT: remove_timeout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Load the output register when it is empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* verif/tb_heartbeat_membership_table.sv */
// Testbench for the heartbeat membership table: directed and random words checked by a predictor.
`default_nettype none
module tb_heartbeat_membership_table;
  timeunit 1ns;
  timeprecision 1ps;

  import hmt_pkg::*;

  localparam int POOL_SIZE    = 128;
  localparam int SETTLE_TICKS = TABLE_ENTRIES + 8;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_FAIL_TIMEOUT;
  logic [15:0] cfg_wdata = '0;

  // Predicted table state and timeouts
  bit          tbl_valid  [TABLE_ENTRIES];
  bit          tbl_failed [TABLE_ENTRIES];
  logic [31:0] tbl_id     [TABLE_ENTRIES];
  logic [15:0] tbl_port   [TABLE_ENTRIES];
  logic [31:0] tbl_hb     [TABLE_ENTRIES];
  logic [31:0] tbl_stamp  [TABLE_ENTRIES];
  logic [31:0] now_ticks    = '0;
  logic [15:0] fail_limit   = FAIL_TIMEOUT_RST;
  logic [15:0] remove_limit = REMOVE_TIMEOUT_RST;

  // Replies predicted but not yet seen
  out_t membership_replies[$];
  int unsigned mismatches = 0;

  // Traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // Known peers for random traffic
  logic [31:0] pool_id   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [31:0] pool_hb   [POOL_SIZE];

  heartbeat_membership_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Apply one word to the predicted table and return the reply it causes
  function automatic out_t apply_membership_word(in_t word);
    out_t        reply;
    logic [31:0] age;
    int          hit;
    int          free_slot;
    int unsigned newly_failed;
    int unsigned freed;

    reply        = '0;
    hit          = -1;
    free_slot    = -1;
    newly_failed = 0;
    freed        = 0;
    if (word.kind == KIND_TICK) begin
      if (now_ticks != TIME_MAX) now_ticks = now_ticks + 1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          age = now_ticks - tbl_stamp[i];
          if (tbl_failed[i]) begin
            if (age >= {16'd0, remove_limit}) begin
              tbl_valid[i]  = 1'b0;
              tbl_failed[i] = 1'b0;
              freed++;
            end
          end else if (age >= {16'd0, fail_limit}) begin
            tbl_failed[i] = 1'b1;
            newly_failed++;
          end
        end
      end
      reply.status        = ST_TICK;
      reply.failed_count  = OUT_CNT_W'(newly_failed);
      reply.removed_count = OUT_CNT_W'(freed);
      return reply;
    end

    // Search for the lowest matching slot and the lowest free one
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0) begin
        if (tbl_valid[i]) begin
          if (tbl_id[i] == word.peer_id && tbl_port[i] == word.peer_port) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
    end

    if (hit >= 0) begin
      if (!tbl_failed[hit] && word.heartbeat > tbl_hb[hit]) begin
        tbl_hb[hit]    = word.heartbeat;
        tbl_stamp[hit] = now_ticks;
        reply.status   = ST_REFRESHED;
      end else begin
        reply.status = ST_UNCHANGED;
      end
      reply.entry_index = OUT_IDX_W'(hit);
    end else if (free_slot < 0) begin
      reply.status = ST_FULL;
    end else begin
      tbl_valid[free_slot]  = 1'b1;
      tbl_failed[free_slot] = 1'b0;
      tbl_id[free_slot]     = word.peer_id;
      tbl_port[free_slot]   = word.peer_port;
      tbl_hb[free_slot]     = word.heartbeat;
      tbl_stamp[free_slot]  = now_ticks;
      reply.status          = ST_INSERTED;
      reply.entry_index     = OUT_IDX_W'(free_slot);
    end
    return reply;
  endfunction

  // Compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (membership_replies.size() == 0) begin
        $error("unexpected reply: status %0d", out_data.status);
        mismatches++;
      end else begin
        want = membership_replies.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index,
                 out_data.entry_index);
          mismatches++;
        end
        if (out_data.failed_count !== want.failed_count) begin
          $error("failed_count: expected %0d, got %0d", want.failed_count,
                 out_data.failed_count);
          mismatches++;
        end
        if (out_data.removed_count !== want.removed_count) begin
          $error("removed_count: expected %0d, got %0d", want.removed_count,
                 out_data.removed_count);
          mismatches++;
        end
      end
    end
  end

  function automatic in_t make_update(logic [31:0] id, logic [15:0] port, logic [31:0] hb);
    in_t word;
    word.kind      = KIND_UPDATE;
    word.peer_id   = id;
    word.peer_port = port;
    word.heartbeat = hb;
    return word;
  endfunction

  // Tick with junk in the update fields, which the block must ignore
  function automatic in_t make_tick();
    in_t word;
    word.kind      = KIND_TICK;
    word.peer_id   = $urandom;
    word.peer_port = 16'($urandom);
    word.heartbeat = $urandom;
    return word;
  endfunction

  // Offer one word, hold it until taken, then predict its reply
  task automatic send_word(input in_t word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    membership_replies.insert(membership_replies.size(), apply_membership_word(word));
  endtask

  // Drop valid, let every reply drain, then let the scan engine settle
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (membership_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic program_timeouts(logic [15:0] fail_ticks, logic [15:0] remove_ticks);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FAIL_TIMEOUT;
    cfg_wdata <= fail_ticks;
    @(posedge clk);
    fail_limit = fail_ticks;
    cfg_index <= CFG_REMOVE_TIMEOUT;
    cfg_wdata <= remove_ticks;
    @(posedge clk);
    remove_limit = remove_ticks;
    cfg_we <= 1'b0;
  endtask

  // Insert, refresh, equal and smaller heartbeats, field extremes, shared id
  task automatic test_update_cases();
    send_word(make_update(32'h0, 16'h0, 32'h0));
    send_word(make_update(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_update(32'h0, 16'h0, 32'h1));
    send_word(make_update(32'h0, 16'h0, 32'h1));
    send_word(make_update(32'h0, 16'h0, 32'h0));
    send_word(make_update(32'h0, 16'h1, 32'h8000_0000));
    send_word(make_update(32'hFFFF_FFFF, 16'h0, 32'h7FFF_FFFF));
    send_word(make_update(32'hFFFF_FFFF, 16'hFFFF, 32'h0));
    send_word(make_tick());
  endtask

  // Mark entries failed, leave failed entries alone, then free them
  task automatic test_failure_and_removal();
    program_timeouts(16'd2, 16'd3);
    send_word(make_tick());
    send_word(make_update(32'h0, 16'h0, 32'hFFFF_FFFF));
    send_word(make_update(32'hFFFF_FFFF, 16'hFFFF, 32'h1234_5678));
    send_word(make_tick());
    send_word(make_update(32'h0, 16'h1, 32'h5));
    send_word(make_update(32'hA5A5_5A5A, 16'h5AA5, 32'h3));
  endtask

  // Zero timeouts: fail on the next tick, not freed in that same sweep
  task automatic test_zero_timeouts();
    program_timeouts(16'd0, 16'd0);
    send_word(make_update(32'h0, 16'h1, 32'h6));
    send_word(make_tick());
    send_word(make_update(32'h0, 16'h1, 32'h7));
    send_word(make_tick());
    send_word(make_tick());
  endtask

  task automatic run_traffic_phase(int unsigned words, int unsigned idle_pct,
                                   int unsigned stall, logic [15:0] fail_ticks,
                                   logic [15:0] remove_ticks, int unsigned peers,
                                   int unsigned tick_pct);
    int unsigned k;
    int unsigned roll;
    logic [31:0] hb;
    program_timeouts(fail_ticks, remove_ticks);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (words) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_word(make_tick());
      end else begin
        k    = $urandom_range(0, peers - 1);
        roll = $urandom_range(0, 99);
        hb   = pool_hb[k];
        if (roll < 5) begin
          // unknown peer noise
          send_word(make_update($urandom, 16'($urandom), $urandom));
        end else begin
          if (roll < 70) begin
            hb         = hb + $urandom_range(1, 50);
            pool_hb[k] = hb;
          end else if (roll >= 85) begin
            hb = hb - $urandom_range(1, 50);
          end
          send_word(make_update(pool_id[k], pool_port[k], hb));
        end
      end
    end
  endtask

  // Random traffic over a peer pool, with table overflow and churn
  task automatic test_random_traffic();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_id[k]   = (k % 2 == 1) ? pool_id[k - 1] : $urandom;
      pool_port[k] = 16'($urandom);
      pool_hb[k]   = $urandom;
    end
    run_traffic_phase(300, 0, 0, 16'd3, 16'd6, 40, 25);
    run_traffic_phase(250, 69, 0, 16'd1, 16'd1, 40, 30);
    run_traffic_phase(350, 0, 69, 16'd65535, 16'd65535, 90, 20);
    run_traffic_phase(350, 38, 38, 16'd4, 16'd10, 70, 30);
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_update_cases();
    test_failure_and_removal();
    test_zero_timeouts();
    test_random_traffic();
    wait_until_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
